// File: sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared constants and types for the hsv to rgb pixel converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // hue in 1/64 degree units
    localparam logic [15:0] HUE_TURN     = 16'd23040;
    localparam logic [15:0] HUE_TURN_X2  = 16'd46080;
    localparam logic [11:0] HUE_SECTOR   = 12'd3840;

    localparam logic [7:0]  FULL_SCALE   = 8'd255;

    // 255 * 3840, denominator of the fractional terms
    localparam logic [19:0] FRAC_DEN     = 20'd979200;
    // half of the doubled rounding term, before the exact shift by 8
    localparam logic [27:0] FRAC_HALF    = 28'd489600;
    // 979200 * 2 = 3825 * 512
    localparam logic [11:0] FRAC_DIV     = 12'd3825;
    // floor(2^32 / 3825)
    localparam logic [20:0] FRAC_RECIP   = 21'd1122867;

    // floor(2^24 / 255)
    localparam logic [16:0] FULL_RECIP   = 17'd65793;
    localparam logic [15:0] FULL_HALF    = 16'd127;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage

// File: sv/hsv2rgb_div.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div
// two-stage rounded divide of v*(979200 - x) by 979200, by reciprocal
// ----------------------------------------------------------------------------
module hsv2rgb_div (
    input  logic        i_clk,
    input  logic [27:0] i_prod,
    output logic [7:0]  o_quot
);
    import hsv2rgb_pkg::*;

    logic [19:0] n_m;
    logic [40:0] n_mul;
    logic [19:0] r_m;
    logic [40:0] r_mul;
    logic [8:0]  w_q0;
    logic [20:0] w_back;
    logic [20:0] w_rem;
    logic [8:0]  n_quot;
    logic [7:0]  r_quot;

    // round half up: floor((2n + d) / 2d) with 2d = 3825 * 512
    always_comb begin
        n_m   = 20'((i_prod + FRAC_HALF) >> 8);
        n_mul = 41'(n_m) * 41'(FRAC_RECIP);
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_mul <= n_mul;
    end

    // estimate is low by at most one
    always_comb begin
        w_q0   = r_mul[40:32];
        w_back = 21'(w_q0) * 21'(FRAC_DIV);
        w_rem  = 21'(r_m) - w_back;
        n_quot = (w_rem >= 21'(FRAC_DIV)) ? w_q0 + 9'd1 : w_q0;
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot[7:0];
    end

    assign o_quot = r_quot;

endmodule

// File: sv/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// pixel converter from hue / saturation / value to 8-bit red, green, blue
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  input     i_hue, i_saturation, i_brightness          start / busy
//  result    o_red, o_green, o_blue                     o_valid strobe
//
//  one word per clock in while busy is low
//  the datapath is a seven-stage pipeline (multipliers each registered)
//  busy is high only in reset and the first cycle after it
//  synchronous active-low reset clears the valid bits, payload is not reset
//  the receiver cannot stall, so nothing is ever held back
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness,
    output logic        o_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);
    import hsv2rgb_pkg::*;

    logic        r_busy;
    logic [6:0]  r_vld;
    logic        w_accept;

    // stage 1
    logic [14:0] n1_hm;
    logic [14:0] r1_hm;
    logic [7:0]  r1_sat;
    logic [7:0]  r1_val;
    // stage 2
    t_sector     n2_sector;
    logic [11:0] n2_rem;
    t_sector     r2_sector;
    logic [11:0] r2_rem;
    logic [7:0]  r2_sat;
    logic [7:0]  r2_val;
    logic [15:0] r2_pprod;
    // stage 3
    t_sector     r3_sector;
    logic [7:0]  r3_val;
    logic [19:0] r3_sq;
    logic [19:0] r3_st;
    logic [15:0] n3_px;
    logic [15:0] r3_px;
    logic [32:0] r3_pmul;
    // stage 4
    t_sector     r4_sector;
    logic [27:0] r4_qprod;
    logic [27:0] r4_tprod;
    logic [7:0]  w4_p0;
    logic [15:0] w4_prem;
    logic [7:0]  n4_p;
    logic [7:0]  r4_p;
    // stages 5 and 6
    t_sector     r5_sector;
    logic [7:0]  r5_p;
    t_sector     r6_sector;
    logic [7:0]  r6_p;
    logic [7:0]  w6_q;
    logic [7:0]  w6_t;
    // output stage
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    assign w_accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[5:0], w_accept};
        end
    end

    // hue below three turns, so two compares do the wrap
    always_comb begin
        if (i_hue >= HUE_TURN_X2) begin
            n1_hm = 15'(i_hue - HUE_TURN_X2);
        end else if (i_hue >= HUE_TURN) begin
            n1_hm = 15'(i_hue - HUE_TURN);
        end else begin
            n1_hm = i_hue[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_hm  <= n1_hm;
        r1_sat <= i_saturation;
        r1_val <= i_brightness;
    end

    always_comb begin
        if (r1_hm >= 15'(5 * HUE_SECTOR)) begin
            n2_sector = SEC_MAG_RED;
            n2_rem    = 12'(r1_hm - 15'(5 * HUE_SECTOR));
        end else if (r1_hm >= 15'(4 * HUE_SECTOR)) begin
            n2_sector = SEC_BLU_MAG;
            n2_rem    = 12'(r1_hm - 15'(4 * HUE_SECTOR));
        end else if (r1_hm >= 15'(3 * HUE_SECTOR)) begin
            n2_sector = SEC_CYN_BLU;
            n2_rem    = 12'(r1_hm - 15'(3 * HUE_SECTOR));
        end else if (r1_hm >= 15'(2 * HUE_SECTOR)) begin
            n2_sector = SEC_GRN_CYN;
            n2_rem    = 12'(r1_hm - 15'(2 * HUE_SECTOR));
        end else if (r1_hm >= 15'(HUE_SECTOR)) begin
            n2_sector = SEC_YEL_GRN;
            n2_rem    = 12'(r1_hm - 15'(HUE_SECTOR));
        end else begin
            n2_sector = SEC_RED_YEL;
            n2_rem    = r1_hm[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sector <= n2_sector;
        r2_rem    <= n2_rem;
        r2_sat    <= r1_sat;
        r2_val    <= r1_val;
        r2_pprod  <= 16'(r1_val) * 16'(FULL_SCALE - r1_sat);
    end

    // (2n + 255) / 510 is (n + 127) / 255
    assign n3_px = r2_pprod + FULL_HALF;

    always_ff @(posedge i_clk) begin
        r3_sector <= r2_sector;
        r3_val    <= r2_val;
        r3_sq     <= 20'(r2_sat) * 20'(r2_rem);
        r3_st     <= 20'(r2_sat) * 20'(HUE_SECTOR - r2_rem);
        r3_px     <= n3_px;
        r3_pmul   <= 33'(n3_px) * 33'(FULL_RECIP);
    end

    always_comb begin
        w4_p0   = r3_pmul[31:24];
        w4_prem = r3_px - 16'(w4_p0) * 16'(FULL_SCALE);
        n4_p    = (w4_prem >= 16'(FULL_SCALE)) ? w4_p0 + 8'd1 : w4_p0;
    end

    always_ff @(posedge i_clk) begin
        r4_sector <= r3_sector;
        r4_qprod  <= 28'(r3_val) * 28'(FRAC_DEN - r3_sq);
        r4_tprod  <= 28'(r3_val) * 28'(FRAC_DEN - r3_st);
        r4_p      <= n4_p;
    end

    hsv2rgb_div u_div_q (
        .i_clk  (i_clk),
        .i_prod (r4_qprod),
        .o_quot (w6_q)
    );

    hsv2rgb_div u_div_t (
        .i_clk  (i_clk),
        .i_prod (r4_tprod),
        .o_quot (w6_t)
    );

    always_ff @(posedge i_clk) begin
        r5_sector <= r4_sector;
        r5_p      <= r4_p;
        r6_sector <= r5_sector;
        r6_p      <= r5_p;
    end

    // v is the brightness itself, routed straight from the input copy
    logic [7:0] r5_v;
    logic [7:0] r6_v;
    logic [7:0] r4_v;

    always_ff @(posedge i_clk) begin
        r4_v <= r3_val;
        r5_v <= r4_v;
        r6_v <= r5_v;
    end

    always_comb begin
        case (r6_sector)
            SEC_RED_YEL: begin
                n_red = r6_v;  n_green = w6_t;  n_blue = r6_p;
            end
            SEC_YEL_GRN: begin
                n_red = w6_q;  n_green = r6_v;  n_blue = r6_p;
            end
            SEC_GRN_CYN: begin
                n_red = r6_p;  n_green = r6_v;  n_blue = w6_t;
            end
            SEC_CYN_BLU: begin
                n_red = r6_p;  n_green = w6_q;  n_blue = r6_v;
            end
            SEC_BLU_MAG: begin
                n_red = w6_t;  n_green = r6_p;  n_blue = r6_v;
            end
            default: begin
                n_red = r6_v;  n_green = r6_p;  n_blue = w6_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign busy    = r_busy;
    assign o_valid = r_vld[6];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// File: sv/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port-level checks on latency and color results of the converter
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] i_saturation,
    input logic [7:0] i_brightness,
    input logic       o_valid,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    // every accepted word comes out as a result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_valid)
        else $error("accepted word produced no result");

    // no result without a matching accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 7))
        else $error("result without an accepted word");

    // zero saturation gives grey at the brightness
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_saturation == 8'd0) |-> ##7
        (o_red == o_green && o_green == o_blue && o_red == $past(i_brightness, 7)))
        else $error("grey pixel mismatch");

    // one channel always carries the brightness
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red == $past(i_brightness, 7) ||
                     o_green == $past(i_brightness, 7) ||
                     o_blue == $past(i_brightness, 7)))
        else $error("no channel equals brightness");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_saturation (i_saturation),
    .i_brightness (i_brightness),
    .o_valid      (o_valid),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue)
);
